// File: sv/jvr_pkg.sv
// jvr_pkg: shared types, widths and constants for the jog velocity ramp positioner
// no dependencies; imported by jvr_csr, jvr_ctrl, jvr_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package jvr_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;

   // field widths
   localparam int DT_W    = 16;
   localparam int ACCEL_W = 21;
   localparam int VMAX_W  = 21;
   localparam int HW_W    = 16;
   localparam int POS_W   = 17;
   localparam int SPEED_W = 22;

   // internal widths
   localparam int MAG_W    = ACCEL_W;            // (accel * dt) >> FRAC_BITS
   localparam int VSUM_W   = SPEED_W + 2;        // v + delta and v + nv
   localparam int PROD_W   = VSUM_W + DT_W + 1;  // signed product of sum and dt
   localparam int TRAVEL_W = PROD_W - (FRAC_BITS + 1);
   localparam int WIDE_W   = 27;                 // centre arithmetic

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_RATE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_LIMIT = 3'd4;

   // reset values
   localparam logic [ACCEL_W-1:0] ACCEL_RESET = 21'd112347;
   localparam logic [VMAX_W-1:0]  VMAX_RESET  = 21'd39322;
   localparam logic [HW_W-1:0]    HW_RESET    = 16'd3277;
   localparam logic [POS_W-1:0]   LL_RESET    = '0;
   localparam logic [POS_W-1:0]   RL_RESET    = POS_W'(1) << FRAC_BITS;
   localparam logic [POS_W-1:0]   CENTRE_RESET = POS_W'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [ACCEL_W-1:0] accel_rate;
      logic [VMAX_W-1:0]  max_speed;
      logic [HW_W-1:0]    half_width;
      logic [POS_W-1:0]   left_limit;
      logic [POS_W-1:0]   right_limit;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // latch the input beat, form the velocity step
      logic vel;     // new velocity and velocity sum
      logic mul;     // travel product
      logic commit;  // position update, state and result write
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: sv/jvr_csr.sv
// jvr_csr: apb-style register file holding the motion configuration
// depends on jvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module jvr_csr
   import jvr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;
   logic [CSR_IDX_W-1:0] idx;
   logic wr_en;

   assign idx   = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ACCEL_RATE:  cfg_in.accel_rate  = csr_pwdata[ACCEL_W-1:0];
            REG_MAX_SPEED:   cfg_in.max_speed   = csr_pwdata[VMAX_W-1:0];
            REG_HALF_WIDTH:  cfg_in.half_width  = csr_pwdata[HW_W-1:0];
            REG_LEFT_LIMIT:  cfg_in.left_limit  = csr_pwdata[POS_W-1:0];
            REG_RIGHT_LIMIT: cfg_in.right_limit = csr_pwdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_rate  <= ACCEL_RESET;
         cfg_ff.max_speed   <= VMAX_RESET;
         cfg_ff.half_width  <= HW_RESET;
         cfg_ff.left_limit  <= LL_RESET;
         cfg_ff.right_limit <= RL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_ACCEL_RATE:  csr_prdata = CSR_DATA_W'(cfg_ff.accel_rate);
         REG_MAX_SPEED:   csr_prdata = CSR_DATA_W'(cfg_ff.max_speed);
         REG_HALF_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.half_width);
         REG_LEFT_LIMIT:  csr_prdata = CSR_DATA_W'(cfg_ff.left_limit);
         REG_RIGHT_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.right_limit);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/jvr_ctrl.sv
// jvr_ctrl: sequencer that steps one tick through the datapath
// depends on jvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module jvr_ctrl
   import jvr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_VEL  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_POS  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_VEL;
            end
         end
         ST_VEL: begin
            cmd.vel  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_POS;
         end
         ST_POS: begin
            // wait here while the previous result is still unclaimed
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_starts_tick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_VEL))
      else $error("accepted beat did not start the velocity step");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result written over an unclaimed result");

   a_mul_after_vel: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |-> $past(cmd.vel))
      else $error("travel product formed before the velocity step");

endmodule

`default_nettype wire

// File: sv/jvr_datapath.sv
// jvr_datapath: velocity ramp, trapezoid travel, limit clamp and result register
// depends on jvr_pkg; sequenced by jvr_ctrl
`timescale 1ns / 1ps
`default_nettype none

module jvr_datapath
   import jvr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  cmd_type                cmd,
   output status_type             status,
   input  wire logic [DT_W-1:0]   req_tick_duration,
   input  wire logic              req_jog_left,
   input  wire logic              req_jog_right,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [POS_W-1:0]       rsp_centre_position,
   output logic [SPEED_W-1:0]     rsp_speed_now,
   output logic [POS_W-1:0]       rsp_left_edge,
   output logic [POS_W-1:0]       rsp_right_edge,
   output logic                   rsp_hit_wall
);

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] x);
      logic [POS_W-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (x > $signed({{(WIDE_W-POS_W){1'b0}}, POS_MAX})) begin
         r = POS_MAX;
      end else begin
         r = x[POS_W-1:0];
      end
      return r;
   endfunction

   // tick state
   logic [POS_W-1:0]          centre_ff, centre_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;

   // per-tick working registers
   logic [DT_W-1:0]            dt_ff;
   logic                       left_ff, right_ff;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic signed [SPEED_W-1:0]  nv_ff, nv_in;
   logic signed [VSUM_W-1:0]   sum_ff, sum_in;
   logic signed [TRAVEL_W-1:0] travel_ff, travel_in;

   // result register
   logic                 rsp_valid_ff;
   logic [POS_W-1:0]     out_centre_ff, out_left_ff, out_right_ff;
   logic [SPEED_W-1:0]   out_speed_ff;
   logic                 out_hit_ff;
   logic [POS_W-1:0]     edge_l_in, edge_r_in;
   logic                 hit_in;

   logic [ACCEL_W+DT_W-1:0]  accel_prod;
   logic signed [VSUM_W-1:0] v_ext, mag_ext, vmax_ext, delta, nv_raw, nv_sat, nv_fin;
   logic                     no_req;
   logic signed [PROD_W-1:0] travel_prod;
   logic signed [WIDE_W-1:0] c_raw, c_clamp, hw_ext, ll_ext, rl_ext;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // velocity step magnitude, formed as the beat is taken
   assign accel_prod = cfg.accel_rate * req_tick_duration;
   assign mag_in     = accel_prod[FRAC_BITS+MAG_W-1:FRAC_BITS];

   // new velocity: ramp, saturate, stop at zero when coasting
   always_comb begin
      v_ext    = {{(VSUM_W-SPEED_W){speed_ff[SPEED_W-1]}}, speed_ff};
      mag_ext  = {{(VSUM_W-MAG_W){1'b0}}, mag_ff};
      vmax_ext = {{(VSUM_W-VMAX_W){1'b0}}, cfg.max_speed};
      no_req   = (left_ff == right_ff);
      if (no_req) begin
         if (v_ext == 0) begin
            delta = '0;
         end else if (v_ext > 0) begin
            delta = -mag_ext;
         end else begin
            delta = mag_ext;
         end
      end else if (right_ff) begin
         delta = mag_ext;
      end else begin
         delta = -mag_ext;
      end
      nv_raw = v_ext + delta;
      if (nv_raw > vmax_ext) begin
         nv_sat = vmax_ext;
      end else if (nv_raw < -vmax_ext) begin
         nv_sat = -vmax_ext;
      end else begin
         nv_sat = nv_raw;
      end
      if (no_req && ((v_ext > 0 && nv_sat < 0) || (v_ext < 0 && nv_sat > 0))) begin
         nv_fin = '0;
      end else begin
         nv_fin = nv_sat;
      end
      nv_in  = nv_fin[SPEED_W-1:0];
      sum_in = v_ext + nv_fin;
   end

   // trapezoid travel, floor division by an arithmetic slice
   assign travel_prod = sum_ff * $signed({1'b0, dt_ff});
   assign travel_in   = travel_prod[PROD_W-1:FRAC_BITS+1];

   // centre update and limit clamp, left limit first
   always_comb begin
      hw_ext = {{(WIDE_W-HW_W){1'b0}}, cfg.half_width};
      ll_ext = {{(WIDE_W-POS_W){1'b0}}, cfg.left_limit};
      rl_ext = {{(WIDE_W-POS_W){1'b0}}, cfg.right_limit};
      c_raw  = $signed({{(WIDE_W-POS_W){1'b0}}, centre_ff})
             + {{(WIDE_W-TRAVEL_W){travel_ff[TRAVEL_W-1]}}, travel_ff};
      hit_in   = 1'b1;
      speed_in = '0;
      if (c_raw - hw_ext < ll_ext) begin
         c_clamp = ll_ext + hw_ext;
      end else if (c_raw + hw_ext > rl_ext) begin
         c_clamp = rl_ext - hw_ext;
      end else begin
         c_clamp  = c_raw;
         hit_in   = 1'b0;
         speed_in = nv_ff;
      end
      centre_in = sat_pos(c_clamp);
      edge_l_in = sat_pos($signed({{(WIDE_W-POS_W){1'b0}}, centre_in}) - hw_ext);
      edge_r_in = sat_pos($signed({{(WIDE_W-POS_W){1'b0}}, centre_in}) + hw_ext);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dt_ff    <= req_tick_duration;
         left_ff  <= req_jog_left;
         right_ff <= req_jog_right;
         mag_ff   <= mag_in;
      end
      if (cmd.vel) begin
         nv_ff  <= nv_in;
         sum_ff <= sum_in;
      end
      if (cmd.mul) begin
         travel_ff <= travel_in;
      end
      if (cmd.commit) begin
         out_centre_ff <= centre_in;
         out_speed_ff  <= speed_in;
         out_left_ff   <= edge_l_in;
         out_right_ff  <= edge_r_in;
         out_hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff    <= CENTRE_RESET;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            centre_ff    <= centre_in;
            speed_ff     <= speed_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_centre_position = out_centre_ff;
   assign rsp_speed_now       = out_speed_ff;
   assign rsp_left_edge       = out_left_ff;
   assign rsp_right_edge      = out_right_ff;
   assign rsp_hit_wall        = out_hit_ff;

   a_wall_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_wall) |-> (rsp_speed_now == '0))
      else $error("clamped result with nonzero speed");

   a_edges_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_edge <= rsp_centre_position)
                    && (rsp_centre_position <= rsp_right_edge))
      else $error("edges out of order around the centre");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (centre_ff == rsp_centre_position)
                     && (speed_ff == $signed(rsp_speed_now)))
      else $error("result differs from stored state");

endmodule

`default_nettype wire

// File: sv/jog_velocity_ramp_positioner.sv
// jog_velocity_ramp_positioner: top level, register file, sequencer and datapath
// depends on jvr_pkg, jvr_csr, jvr_ctrl, jvr_datapath
`timescale 1ns / 1ps
`default_nettype none

// Jog carriage positioner with a trapezoidal velocity profile. Each input beat
// carries a tick duration and the two jog buttons; one button alone asks for
// motion that way, both or neither lets the carriage coast to a stop at zero
// speed. Velocity ramps by accel_rate * tick_duration, saturates at
// +/- max_speed, and the centre moves by the mean of old and new speed times
// the tick (floored). An edge past a limit clamps the carriage onto that limit,
// zeroes the speed and raises hit_wall; the left limit wins when both trip.
// All quantities are fixed point with 16 fraction bits.
// Sequence: a tick's result beat is presented after the sequencer has run its
// chain of steps: velocity step multiply at accept, velocity update, travel
// multiply, then the position clamp and result write. A new beat is accepted
// only once the sequencer is back in idle after the previous result write.
// The result sits in an output register, so the next beat is taken while
// it waits; a stalled result holds the sequencer in its last step only.
// Registers sit at byte addresses 0x0 accel_rate, 0x4 max_speed,
// 0x8 half_width, 0xc left_limit, 0x10 right_limit; write them only while idle.

module jog_velocity_ramp_positioner
   import jvr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tick channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [DT_W-1:0]       req_tick_duration,
   input  wire logic                  req_jog_left,
   input  wire logic                  req_jog_right,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [POS_W-1:0]           rsp_centre_position,
   output logic [SPEED_W-1:0]         rsp_speed_now,
   output logic [POS_W-1:0]           rsp_left_edge,
   output logic [POS_W-1:0]           rsp_right_edge,
   output logic                       rsp_hit_wall,
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg;      // live configuration
   cmd_type    cmd;      // per-step strobes from the sequencer
   status_type status;   // result register occupancy

   // register file
   jvr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: idle/accept, velocity, travel multiply, commit
   jvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, carriage state and result register
   jvr_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .status              (status),
      .req_tick_duration   (req_tick_duration),
      .req_jog_left        (req_jog_left),
      .req_jog_right       (req_jog_right),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_centre_position (rsp_centre_position),
      .rsp_speed_now       (rsp_speed_now),
      .rsp_left_edge       (rsp_left_edge),
      .rsp_right_edge      (rsp_right_edge),
      .rsp_hit_wall        (rsp_hit_wall)
   );

endmodule

`default_nettype wire
